// ===== rtl/h2r_pkg.sv =====
// Shared constants, types and helpers of the HSLA to RGBA converter.
// No dependencies; imported by h2r_ramp and hsla_to_rgba_converter.
package h2r_pkg;

    // level formats
    localparam int LEVEL_W = 16;              // clamped Q.15 level, 0..32768
    localparam int RAW_W   = 17;              // signed Q.15 input field
    localparam int HUE_W   = 16;              // Q0.16 fraction of a turn
    localparam int Q30_W   = 31;              // hi, lo and their difference
    localparam int UNIT_W  = 17;              // ramp position, 0..65536
    localparam int PROD_W  = Q30_W + UNIT_W;  // difference times position
    localparam int RAMP_W  = 47;              // ramp value in Q.46, 0..2^46
    localparam int CHAN_W  = 8;

    localparam logic [LEVEL_W-1:0] Q15_ONE   = 16'h8000;
    localparam logic [LEVEL_W-1:0] Q15_HALF  = 16'h4000;
    localparam logic [HUE_W-1:0]   HUE_THIRD = 16'd21845;
    localparam logic [RAMP_W-1:0]  RAMP_ONE  = 47'(1) << 46;

    // hue ramp segment codes
    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    typedef struct packed {
        logic [1:0]        seg;
        logic [UNIT_W-1:0] unit;
    } h2r_seg_t;

    // register load strobes of the per-channel ramp stages
    typedef struct packed {
        logic prod;
        logic level;
        logic scale;
    } h2r_load_t;

    // negative reads as zero, anything above one reads as one
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [RAW_W-1:0] raw);
        logic [LEVEL_W-1:0] res;
        if (raw[RAW_W-1]) begin
            res = '0;
        end else if (raw[LEVEL_W-1:0] > Q15_ONE) begin
            res = Q15_ONE;
        end else begin
            res = raw[LEVEL_W-1:0];
        end
        return res;
    endfunction

    // place a channel hue on the piecewise ramp, t = 6 * hue
    function automatic h2r_seg_t hue_segment(input logic [HUE_W-1:0] hc);
        logic [18:0] t;
        logic [18:0] back;
        h2r_seg_t    res;
        t    = ({3'b0, hc} << 2) + ({3'b0, hc} << 1);
        back = 19'd262144 - t;
        res  = '{seg: SEG_LOW, unit: '0};
        if (t < 19'd65536) begin
            res.seg  = SEG_RISE;
            res.unit = t[UNIT_W-1:0];
        end else if (t < 19'd196608) begin
            res.seg = SEG_HIGH;
        end else if (t < 19'd262144) begin
            res.seg  = SEG_FALL;
            res.unit = back[UNIT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/h2r_ramp.sv =====
// One color channel of the converter: ramp product, level select and 255 scale.
// Depends on h2r_pkg; instantiated three times by hsla_to_rgba_converter.
module h2r_ramp import h2r_pkg::*; (
    input  logic              aclk,
    input  h2r_load_t         load,
    input  h2r_seg_t          seg_in,
    input  logic [Q30_W-1:0]  lo_in,
    input  logic [Q30_W-1:0]  hi_in,
    input  logic [Q30_W-1:0]  diff_in,
    output logic [CHAN_W-1:0] chan
);

    logic [PROD_W-1:0] prod_reg;
    logic [1:0]        seg_reg;
    logic [Q30_W-1:0]  lo_reg;
    logic [Q30_W-1:0]  hi_reg;
    logic [RAMP_W-1:0] level_reg;
    logic [RAMP_W-1:0] level_next;
    logic [CHAN_W-1:0] chan_reg;
    logic [PROD_W-1:0] sum;
    logic [RAMP_W+7:0] scaled;

    // product stage: level difference times ramp position
    always_ff @(posedge aclk) begin
        if (load.prod) begin
            prod_reg <= PROD_W'(diff_in) * PROD_W'(seg_in.unit);
            seg_reg  <= seg_in.seg;
            lo_reg   <= lo_in;
            hi_reg   <= hi_in;
        end
    end

    // level select per segment, limited to one
    always_comb begin
        sum = {1'b0, lo_reg, 16'h0} + prod_reg;
        unique case (seg_reg)
            SEG_RISE, SEG_FALL: level_next = sum[RAMP_W-1:0];
            SEG_HIGH:           level_next = {hi_reg, 16'h0};
            default:            level_next = {lo_reg, 16'h0};
        endcase
        if (sum[PROD_W-1] && (seg_reg == SEG_RISE || seg_reg == SEG_FALL)) begin
            level_next = RAMP_ONE;
        end else if (level_next > RAMP_ONE) begin
            level_next = RAMP_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.level) begin
            level_reg <= level_next;
        end
    end

    // scale by 255 as 256x minus x, keep the integer part
    assign scaled = {level_reg, 8'h0} - {8'h0, level_reg};

    always_ff @(posedge aclk) begin
        if (load.scale) begin
            chan_reg <= scaled[RAMP_W+6:RAMP_W-1];
        end
    end

    assign chan = chan_reg;

endmodule

// ===== rtl/hsla_to_rgba_converter.sv =====
// HSLA to RGBA converter top level: six-stage pipeline and handshake control.
// Depends on h2r_pkg and h2r_ramp.
//
// Converts one HSLA color per clock cycle into 8-bit red, green, blue and alpha.
// A request accepted on s_ passes through every stage to its result on m_; with
// m_ready held high one request is taken every cycle. Each of the six pipeline
// stages carries its own valid bit and holds its item only while the stage after
// it is full and stalled, so back pressure on m_ready fills empty stages first
// and s_ready drops only when all six stages hold an item. The stages are:
// input clamp and hue offsets, hi level multiply and hue segment, lo level and
// level difference, ramp multiply, level select and clamp, and the 255 scale
// into the output register.
module hsla_to_rgba_converter import h2r_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [HUE_W-1:0]  s_hue,
    input  logic [RAW_W-1:0]  s_saturation,
    input  logic [RAW_W-1:0]  s_lightness,
    input  logic [RAW_W-1:0]  s_opacity,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red,
    output logic [CHAN_W-1:0] m_green,
    output logic [CHAN_W-1:0] m_blue,
    output logic [CHAN_W-1:0] m_alpha
);

    localparam int NSTAGE = 6;
    localparam int NCHAN  = 3;

    logic [NSTAGE:1]  vld_reg;
    logic [NSTAGE:1]  vld_next;
    logic [NSTAGE:1]  rdy;
    logic [NSTAGE:1]  feed;

    // stage 1
    logic [HUE_W-1:0]   hue1_reg [NCHAN];
    logic [LEVEL_W-1:0] sat1_reg;
    logic [LEVEL_W-1:0] lit1_reg;
    logic [CHAN_W-1:0]  alpha1_reg;
    logic [LEVEL_W-1:0] opa_clamp;
    logic [23:0]        opa_scaled;
    // stage 2
    logic [Q30_W-1:0]   hi2_reg;
    logic [LEVEL_W-1:0] lit2_reg;
    h2r_seg_t           seg2_reg [NCHAN];
    logic [CHAN_W-1:0]  alpha2_reg;
    logic [UNIT_W-1:0]  mul_a;
    logic [UNIT_W-1:0]  mul_b;
    logic [Q30_W-1:0]   hi_base;
    logic [2*UNIT_W-1:0] hi_prod;
    // stage 3
    logic [Q30_W-1:0]   lo3_reg;
    logic [Q30_W-1:0]   hi3_reg;
    logic [Q30_W-1:0]   diff3_reg;
    h2r_seg_t           seg3_reg [NCHAN];
    logic [CHAN_W-1:0]  alpha3_reg;
    logic [Q30_W:0]     lo_wide;
    // alpha delay through the ramp stages
    logic [CHAN_W-1:0]  alpha4_reg;
    logic [CHAN_W-1:0]  alpha5_reg;
    logic [CHAN_W-1:0]  alpha6_reg;
    logic [CHAN_W-1:0]  chan [NCHAN];
    h2r_load_t          ramp_load;

    // ready chain: a stage takes a new item when empty or when it passes its own on
    always_comb begin
        rdy[NSTAGE] = !vld_reg[NSTAGE] || m_ready;
        for (int i = NSTAGE - 1; i >= 1; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        feed[1] = s_valid;
        for (int i = 2; i <= NSTAGE; i++) begin
            feed[i] = vld_reg[i-1];
        end
        for (int i = 1; i <= NSTAGE; i++) begin
            vld_next[i] = rdy[i] ? feed[i] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = vld_reg[NSTAGE];

    // stage 1: clamp levels, channel hues, alpha scale
    assign opa_clamp  = clamp_level(s_opacity);
    assign opa_scaled = {opa_clamp, 8'h0} - {8'h0, opa_clamp};

    always_ff @(posedge aclk) begin
        if (rdy[1] && s_valid) begin
            hue1_reg[0] <= s_hue + HUE_THIRD;
            hue1_reg[1] <= s_hue;
            hue1_reg[2] <= s_hue - HUE_THIRD;
            sat1_reg    <= clamp_level(s_saturation);
            lit1_reg    <= clamp_level(s_lightness);
            alpha1_reg  <= opa_scaled[22:15];
        end
    end

    // stage 2: hi level as base plus one product, hue segments
    always_comb begin
        if (lit1_reg <= Q15_HALF) begin
            mul_a   = {1'b0, lit1_reg};
            mul_b   = {1'b0, Q15_ONE} + {1'b0, sat1_reg};
            hi_base = '0;
        end else begin
            mul_a   = {1'b0, sat1_reg};
            mul_b   = {1'b0, Q15_ONE} - {1'b0, lit1_reg};
            hi_base = {lit1_reg, 15'h0};
        end
        hi_prod = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2] && vld_reg[1]) begin
            hi2_reg    <= hi_base + hi_prod[Q30_W-1:0];
            lit2_reg   <= lit1_reg;
            alpha2_reg <= alpha1_reg;
            for (int c = 0; c < NCHAN; c++) begin
                seg2_reg[c] <= hue_segment(hue1_reg[c]);
            end
        end
    end

    // stage 3: lo level and the hi minus lo span
    assign lo_wide = {lit2_reg, 16'h0} - {1'b0, hi2_reg};

    always_ff @(posedge aclk) begin
        if (rdy[3] && vld_reg[2]) begin
            lo3_reg    <= lo_wide[Q30_W-1:0];
            hi3_reg    <= hi2_reg;
            diff3_reg  <= hi2_reg - lo_wide[Q30_W-1:0];
            seg3_reg   <= seg2_reg;
            alpha3_reg <= alpha2_reg;
        end
    end

    // stages 4 to 6: per-channel ramp
    assign ramp_load = '{prod:  rdy[4] && vld_reg[3],
                         level: rdy[5] && vld_reg[4],
                         scale: rdy[6] && vld_reg[5]};

    for (genvar c = 0; c < NCHAN; c++) begin : g_chan
        h2r_ramp u_ramp (
            .aclk    (aclk),
            .load    (ramp_load),
            .seg_in  (seg3_reg[c]),
            .lo_in   (lo3_reg),
            .hi_in   (hi3_reg),
            .diff_in (diff3_reg),
            .chan    (chan[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (ramp_load.prod) begin
            alpha4_reg <= alpha3_reg;
        end
        if (ramp_load.level) begin
            alpha5_reg <= alpha4_reg;
        end
        if (ramp_load.scale) begin
            alpha6_reg <= alpha5_reg;
        end
    end

    assign m_red   = chan[0];
    assign m_green = chan[1];
    assign m_blue  = chan[2];
    assign m_alpha = alpha6_reg;

    // lo never exceeds hi and hi never exceeds one
    a_lo_below_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (lo3_reg <= hi3_reg && hi3_reg <= 31'h4000_0000))
        else $error("level pair out of order");

    // span plus lo gives back hi
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (Q30_W'(lo3_reg + diff3_reg) == hi3_reg))
        else $error("level span mismatch");

    // an empty first stage always takes a request
    a_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[1] |-> s_ready)
        else $error("input stalled with empty first stage");

    // a stalled stage 5 keeps its item
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[5] && !rdy[6]) |=> vld_reg[5])
        else $error("stalled item dropped");

    // pipeline full and output stalled means no request is taken
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> !s_ready)
        else $error("request taken into full pipeline");

endmodule

// ===== tb/tb_hsla_to_rgba_converter.sv =====
// Self-checking testbench for the HSLA to RGBA converter: directed and random requests,
// random idling on both channels, one long output stall, predictor-based checks.
// Depends on h2r_pkg and the hsla_to_rgba_converter RTL.
module tb_hsla_to_rgba_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import h2r_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;
    localparam int RAMP_FRAC    = 46;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [RAW_W-1:0] sat;
        logic [RAW_W-1:0] light;
        logic [RAW_W-1:0] opac;
    } hsla_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        hsla_req_t req;
        logic      typed;   // expected color typed in below
        rgba_t     want;
    } color_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [HUE_W-1:0]  s_hue = '0;
    logic [RAW_W-1:0]  s_saturation = '0;
    logic [RAW_W-1:0]  s_lightness = '0;
    logic [RAW_W-1:0]  s_opacity = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAN_W-1:0] m_red;
    logic [CHAN_W-1:0] m_green;
    logic [CHAN_W-1:0] m_blue;
    logic [CHAN_W-1:0] m_alpha;

    rgba_t expected_rgba[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    sender_idle_pct = 0;
    int    receiver_idle_pct = 0;
    bit    hold_request = 1'b0;

    hsla_to_rgba_converter i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .s_opacity    (s_opacity),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha)
    );

    // directed requests: extremes, clamping, segment edges around each sixth of a turn
    color_row_t directed_rows[] = '{
        '{'{16'd0,     17'h00000, 17'h00000, 17'h00000}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
        '{'{16'hFFFF,  17'h0FFFF, 17'h10000, 17'h0FFFF}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
        '{'{16'd0,     17'h08000, 17'h08000, 17'h08000}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{'{16'd1234,  17'h1FFFF, 17'h04000, 17'h04000}, 1'b1, '{8'd127, 8'd127, 8'd127, 8'd127}},
        '{'{16'd0,     17'h08000, 17'h04000, 17'h08000}, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd255}},
        '{'{16'd777,   17'h05555, 17'h00000, 17'h08001}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
        '{'{16'd40000, 17'h08000, 17'h00000, 17'h10000}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
        '{'{16'd10922, 17'h08000, 17'h04000, 17'h08000}, 1'b0, '0},
        '{'{16'd10923, 17'h08000, 17'h04000, 17'h08000}, 1'b0, '0},
        '{'{16'd21845, 17'h08000, 17'h04000, 17'h08000}, 1'b0, '0},
        '{'{16'd32767, 17'h08000, 17'h04000, 17'h07FFF}, 1'b0, '0},
        '{'{16'd32768, 17'h08000, 17'h04000, 17'h00001}, 1'b0, '0},
        '{'{16'd43690, 17'h08000, 17'h04000, 17'h1FFFF}, 1'b0, '0},
        '{'{16'd43691, 17'h08000, 17'h04000, 17'h0AAAA}, 1'b0, '0},
        '{'{16'd54613, 17'h06000, 17'h03000, 17'h05555}, 1'b0, '0},
        '{'{16'd54614, 17'h06000, 17'h03000, 17'h02AAA}, 1'b0, '0},
        '{'{16'd5461,  17'h04000, 17'h04001, 17'h08000}, 1'b0, '0},
        '{'{16'd5462,  17'h08000, 17'h06000, 17'h08000}, 1'b0, '0},
        '{'{16'd65535, 17'h08001, 17'h02000, 17'h08000}, 1'b0, '0},
        '{'{16'd12345, 17'h0FFFF, 17'h04001, 17'h08000}, 1'b0, '0},
        '{'{16'd23456, 17'h03000, 17'h08001, 17'h08000}, 1'b0, '0},
        '{'{16'd34567, 17'h03000, 17'h1FFFF, 17'h08000}, 1'b0, '0},
        '{'{16'd45678, 17'h07FFF, 17'h07FFF, 17'h07FFF}, 1'b0, '0},
        '{'{16'd56789, 17'h00001, 17'h00001, 17'h00001}, 1'b0, '0}
    };

    // clock
    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // signed Q.15 field limited to 0..1
    function automatic longint unsigned q15_level(input logic [RAW_W-1:0] raw);
        longint signed v;
        v = longint'($signed(raw));
        if (v < 0) begin
            v = 0;
        end else if (v > longint'(Q15_ONE)) begin
            v = longint'(Q15_ONE);
        end
        return longint'(unsigned'(v));
    endfunction

    // one channel: position on the hue ramp between lo and hi, scaled to 8 bits
    function automatic logic [CHAN_W-1:0] channel_from_ramp(input logic [HUE_W-1:0] hc,
                                                            input longint unsigned lo,
                                                            input longint unsigned hi);
        longint unsigned t;
        longint unsigned span;
        longint unsigned level;
        longint unsigned full;
        t     = longint'(hc) * 6;
        span  = hi - lo;
        full  = longint'(1) << RAMP_FRAC;
        if (t < 65536) begin
            level = (lo << 16) + span * t;
        end else if (t < 196608) begin
            level = hi << 16;
        end else if (t < 262144) begin
            level = (lo << 16) + span * (262144 - t);
        end else begin
            level = lo << 16;
        end
        if (level > full) begin
            level = full;
        end
        return CHAN_W'((level * 255) >> RAMP_FRAC);
    endfunction

    // expected color of one request
    function automatic rgba_t predict_rgba(input hsla_req_t r);
        longint unsigned  s;
        longint unsigned  l;
        longint unsigned  a;
        longint unsigned  hi;
        longint unsigned  lo;
        logic [HUE_W-1:0] red_hue;
        logic [HUE_W-1:0] blue_hue;
        rgba_t            res;
        s = q15_level(r.sat);
        l = q15_level(r.light);
        a = q15_level(r.opac);
        if (l <= longint'(Q15_HALF)) begin
            hi = l * (longint'(Q15_ONE) + s);
        end else begin
            hi = (l + s) * longint'(Q15_ONE) - l * s;
        end
        lo       = 2 * l * longint'(Q15_ONE) - hi;
        red_hue  = r.hue + HUE_THIRD;
        blue_hue = r.hue - HUE_THIRD;
        res.red   = channel_from_ramp(red_hue, lo, hi);
        res.green = channel_from_ramp(r.hue, lo, hi);
        res.blue  = channel_from_ramp(blue_hue, lo, hi);
        res.alpha = CHAN_W'((a * 255) >> 15);
        return res;
    endfunction

    // mostly in-range levels, some raw fields over the whole 17-bit range
    function automatic logic [RAW_W-1:0] random_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return RAW_W'($urandom_range(32768, 0));
        end else if (pick < 70) begin
            return (pick < 65) ? RAW_W'(0) : RAW_W'(Q15_ONE);
        end else begin
            return RAW_W'($urandom_range(131071, 0));
        end
    endfunction

    function automatic hsla_req_t random_request();
        hsla_req_t r;
        r.hue   = HUE_W'($urandom_range(65535, 0));
        r.sat   = random_level();
        r.light = random_level();
        r.opac  = random_level();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        end
        error_count++;
    endtask

    // offer one request after a random gap, hold it until taken, log its expected color
    task automatic send_request(input hsla_req_t r, input logic typed, input rgba_t want);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= r.hue;
        s_saturation <= r.sat;
        s_lightness  <= r.light;
        s_opacity    <= r.opac;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_rgba.insert(expected_rgba.size(), typed ? want : predict_rgba(r));
    endtask

    task automatic send_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_request = 1'b1;
            end
            send_request(random_request(), 1'b0, '0);
        end
    endtask

    // receiver: random back pressure plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // compare each returned color with the oldest expected one
    always @(posedge aclk) begin : check_results
        rgba_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rgba.size() == 0) begin
                report_mismatch("unexpected result, red", int'(m_red), 0);
            end else begin
                oldest = expected_rgba.pop_front();
                if (m_red !== oldest.red) begin
                    report_mismatch("red", int'(m_red), int'(oldest.red));
                end
                if (m_green !== oldest.green) begin
                    report_mismatch("green", int'(m_green), int'(oldest.green));
                end
                if (m_blue !== oldest.blue) begin
                    report_mismatch("blue", int'(m_blue), int'(oldest.blue));
                end
                if (m_alpha !== oldest.alpha) begin
                    report_mismatch("alpha", int'(m_alpha), int'(oldest.alpha));
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d colors outstanding", expected_rgba.size());
            $display("** hsla_to_rgba_converter: FAILED **");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        sender_idle_pct   = 23;
        receiver_idle_pct = 77;
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        send_random(450, -1);

        // sender mostly idle, receiver mostly ready
        sender_idle_pct   = 77;
        receiver_idle_pct = 23;
        send_random(470, -1);

        // full rate, with one long output stall to fill the pipeline
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random(460, 100);

        s_valid <= 1'b0;
        while (expected_rgba.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("** hsla_to_rgba_converter: PASSED **");
        end else begin
            $display("** hsla_to_rgba_converter: FAILED **");
        end
        $finish;
    end

endmodule
